@@ sv/nsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants for the Newton square root block
// Field widths, register reset value and the divider status bundle.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int VALUE_W           = 32;
  localparam int ROOT_W            = 25;
  localparam int ITER_W            = 6;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(20);
  // largest positive root_out
  localparam logic [ROOT_W-1:0] ROOT_MAX   = {1'b0, {(ROOT_W-1){1'b1}}};

  typedef struct packed {
    logic busy;
    logic done;
  } nsr_div_status_t;

endpackage
`default_nettype wire

@@ sv/nsr_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_divider: radix-2 restoring unsigned divider
// One quotient bit per cycle while busy; done pulses at the end of the divide.
// ----------------------------------------------------------------------------
module nsr_divider #(
  parameter int W = 47
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [W-1:0]            dividend,
  input  wire logic [W-1:0]            divisor,
  output logic [W-1:0]                 quotient,
  output nsr_pkg::nsr_div_status_t     status
);
  import nsr_pkg::*;

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [W:0]       trial;
  logic             fits;
  logic [W:0]       rem_next;
  logic [W-1:0]     quo_next;

  // shift in the next dividend bit, subtract if the divisor fits
  always_comb begin
    trial    = {rem[W-1:0], quo[W-1]};
    fits     = (trial >= {1'b0, dsr});
    rem_next = fits ? (trial - {1'b0, dsr}) : trial;
    quo_next = {quo[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

@@ sv/newton_square_root.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newton_square_root: fixed-point square root by Newton-Raphson
// Refines guess = (guess + X/guess)/2 with X = value << FRAC_BITS, starting
// from the operand, for iteration_count steps; one serial divider is reused.
// ----------------------------------------------------------------------------
// Sequence: negative, zero and exactly-one operands go from IDLE straight to FIN and
//   the output register; others run N steps (default Q16.16), each one bit-serial
//   divide of FRAC_BITS+31 quotient bits plus the LAUNCH and WAIT sequencer states.
// Throughput: one request at a time; in_stall is high until the result has
//   moved into the output register, which then waits for the consumer.
// Reset (rst, synchronous): sequencer idle, output empty, iteration_count = 20.
module newton_square_root #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration: iteration_count
  input  wire logic                                cfg_we,
  input  wire logic [nsr_pkg::ITER_W-1:0]          cfg_wdata,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [nsr_pkg::VALUE_W-1:0]  value_in,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [nsr_pkg::ROOT_W-1:0]        root_out,
  output logic                                     negative_error
);
  import nsr_pkg::*;

  // operand magnitude is at most 31 bits, so X and every guess fit here
  localparam int MAG_W = VALUE_W - 1;
  localparam int BIG_W = MAG_W + FRAC_BITS;

  localparam logic [ROOT_W-1:0]  ONE_ROOT  = ROOT_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]  NEG_ONE   = ROOT_W'(~ONE_ROOT + ROOT_W'(1));
  localparam logic [VALUE_W-1:0] ONE_VALUE = VALUE_W'(1) << FRAC_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]        state;
  logic [ITER_W-1:0] iteration_count;
  logic [ITER_W-1:0] iter_run;    // step count latched per request
  logic [ITER_W-1:0] step;
  logic [MAG_W-1:0]  operand;
  logic [BIG_W-1:0]  guess;
  logic              neg;         // negative operand
  logic              bypass;      // zero or exactly 1.0: passed through

  logic [BIG_W-1:0]  div_quotient;
  logic [BIG_W-1:0]  div_divisor;
  logic [BIG_W-1:0]  div_dividend;
  logic              div_start;
  nsr_div_status_t   div_status;

  logic [BIG_W:0]    sum;
  logic [ROOT_W-1:0] root_next;
  logic              in_take;
  logic              out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // ---- shared divider: quotient = (operand << FRAC_BITS) / guess ----
  assign div_dividend = {operand, {FRAC_BITS{1'b0}}};
  // a zero guess cannot occur for a positive operand; guard it anyway
  assign div_divisor  = (guess == '0) ? BIG_W'(1) : guess;
  assign div_start    = (state == ST_LAUNCH) && (step != iter_run);

  nsr_divider #(
    .W (BIG_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // Newton update, halving truncates
  assign sum = {1'b0, div_divisor} + {1'b0, div_quotient};

  // final result selection: -1.0 for negative operands, saturation of oversize roots
  always_comb begin
    if (neg) begin
      root_next = NEG_ONE;
    end else if (bypass) begin
      root_next = guess[ROOT_W-1:0];
    end else if (guess > BIG_W'(ROOT_MAX)) begin
      root_next = ROOT_MAX;
    end else begin
      root_next = guess[ROOT_W-1:0];
    end
  end

  // ---- configuration register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
    end else if (cfg_we) begin
      iteration_count <= cfg_wdata;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a finishing request refills the output register as it drains
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (value_in[VALUE_W-1] || value_in == $signed(ONE_VALUE)
                || value_in == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_LAUNCH;
            end
          end
        end
        ST_LAUNCH: begin
          if (step == iter_run) begin
            state <= ST_FIN;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_status.done) begin
            state <= ST_LAUNCH;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (in_take) begin
      operand  <= value_in[MAG_W-1:0];
      guess    <= BIG_W'(value_in[MAG_W-1:0]);
      neg      <= value_in[VALUE_W-1];
      bypass   <= (value_in == $signed(ONE_VALUE)) || (value_in == '0);
      iter_run <= iteration_count;
      step     <= '0;
    end else if (state == ST_WAIT && div_status.done) begin
      guess <= sum[BIG_W:1];
      step  <= step + ITER_W'(1);
    end
    if (state == ST_FIN && out_free) begin
      root_out       <= $signed(root_next);
      negative_error <= neg;
    end
  end

  // ---- assertions ----
  a_neg_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && negative_error) |-> (root_out == $signed(NEG_ONE)))
    else $error("negative request did not return -1.0");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == ST_WAIT))
    else $error("divider finished outside the wait state");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAUNCH || state == ST_WAIT) |-> (step <= iter_run))
    else $error("step counter ran past the step count");

endmodule
`default_nettype wire
